// ===== rtl/dc_motor_euler_step_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the DC motor Euler step block
// Concurrent checks clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef DC_MOTOR_EULER_STEP_TOP_ASSERT_SVH
`define DC_MOTOR_EULER_STEP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCME_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dcme_pkg.sv =====
// ---------------------------------------------------------------------------
// dcme_pkg
// Widths, control word types, saturation helpers and the microcode ROM.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcme_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int FRAC_BITS    = 16;
  localparam int STEP_BITS    = 20;
  localparam int CFG_WIDTH    = 31;
  localparam int CFG_IDX_BITS = 3;
  localparam int SPEED_SCALE  = 400;
  localparam int PC_BITS      = 4;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [CFG_WIDTH-1:0]          cfg_t;
  typedef logic [STEP_BITS-1:0]          step_t;
  typedef logic [PC_BITS-1:0]            pc_t;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam val_t SCALE_Q = val_t'(SPEED_SCALE << FRAC_BITS);

  localparam pc_t PC_RESULT   = pc_t'(9);
  localparam pc_t PC_IDLE_OUT = pc_t'(10);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RESISTANCE = 3'd0,
    REG_BACK_EMF   = 3'd1,
    REG_TORQUE     = 3'd2,
    REG_FRICTION   = 3'd3,
    REG_DT_IND     = 3'd4,
    REG_DT_INERTIA = 3'd5,
    REG_END_STEP   = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MA_RES, MA_KE, MA_KM, MA_FRIC, MA_DTL, MA_DTJ, MA_SPD
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_CUR, MB_SPD, MB_DI, MB_DW, MB_SCALE
  } mul_b_t;

  typedef enum logic [2:0] {
    AA_ZERO, AA_VOLT, AA_DI, AA_DW, AA_CUR, AA_SPD
  } alu_a_t;

  typedef enum logic {AB_PROD, AB_LOAD} alu_b_t;
  typedef enum logic {OP_ADD, OP_SUB} alu_op_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_DI, DST_DW, DST_CUR, DST_SPD
  } dst_t;

  typedef enum logic {BR_NONE, BR_IDLE} br_t;

  typedef struct packed {
    logic    mul_en;
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    alu_a_t  alu_a;
    alu_b_t  alu_b;
    alu_op_t alu_op;
    dst_t    dst;
    br_t     branch;
    pc_t     target;
    logic    finish;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    mul_en: 1'b0, mul_a: MA_RES, mul_b: MB_CUR, alu_a: AA_ZERO,
    alu_b: AB_PROD, alu_op: OP_ADD, dst: DST_NONE, branch: BR_NONE,
    target: PC_IDLE_OUT, finish: 1'b0
  };

  // Saturate a sum that grew by one bit.
  function automatic val_t sat_sum(input logic signed [VALUE_WIDTH:0] x);
    val_t r;
    if (x[VALUE_WIDTH] == x[VALUE_WIDTH-1]) begin
      r = x[VALUE_WIDTH-1:0];
    end else if (x[VALUE_WIDTH]) begin
      r = VAL_MIN;
    end else begin
      r = VAL_MAX;
    end
    return r;
  endfunction

  // Floor of a fixed-point product, saturated.
  function automatic val_t sat_prod(input logic signed [2*VALUE_WIDTH-1:0] p);
    logic signed [2*VALUE_WIDTH-1:0] q;
    logic [VALUE_WIDTH:0]            hi;
    val_t                            r;
    q  = p >>> FRAC_BITS;
    hi = q[2*VALUE_WIDTH-1:VALUE_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      r = q[VALUE_WIDTH-1:0];
    end else if (q[2*VALUE_WIDTH-1]) begin
      r = VAL_MIN;
    end else begin
      r = VAL_MAX;
    end
    return r;
  endfunction

  // Microcode ROM: one control word per step.
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t c;
    c = CTRL_NOP;
    case (pc)
      pc_t'(0): begin
        c.mul_en = 1'b1; c.mul_a = MA_RES; c.mul_b = MB_CUR;
        c.branch = BR_IDLE; c.target = PC_IDLE_OUT;
      end
      pc_t'(1): begin
        c.mul_en = 1'b1; c.mul_a = MA_KE; c.mul_b = MB_SPD;
        c.alu_a = AA_VOLT; c.alu_b = AB_PROD; c.alu_op = OP_SUB; c.dst = DST_DI;
      end
      pc_t'(2): begin
        c.mul_en = 1'b1; c.mul_a = MA_KM; c.mul_b = MB_CUR;
        c.alu_a = AA_DI; c.alu_b = AB_PROD; c.alu_op = OP_SUB; c.dst = DST_DI;
      end
      pc_t'(3): begin
        c.mul_en = 1'b1; c.mul_a = MA_FRIC; c.mul_b = MB_SPD;
        c.alu_a = AA_ZERO; c.alu_b = AB_PROD; c.alu_op = OP_ADD; c.dst = DST_DW;
      end
      pc_t'(4): begin
        c.mul_en = 1'b1; c.mul_a = MA_DTL; c.mul_b = MB_DI;
        c.alu_a = AA_DW; c.alu_b = AB_PROD; c.alu_op = OP_SUB; c.dst = DST_DW;
      end
      pc_t'(5): begin
        c.alu_a = AA_DW; c.alu_b = AB_LOAD; c.alu_op = OP_SUB; c.dst = DST_DW;
      end
      pc_t'(6): begin
        c.mul_en = 1'b1; c.mul_a = MA_DTJ; c.mul_b = MB_DW;
        c.alu_a = AA_CUR; c.alu_b = AB_PROD; c.alu_op = OP_ADD; c.dst = DST_CUR;
      end
      pc_t'(7): begin
        c.alu_a = AA_SPD; c.alu_b = AB_PROD; c.alu_op = OP_ADD; c.dst = DST_SPD;
      end
      pc_t'(8): begin
        c.mul_en = 1'b1; c.mul_a = MA_SPD; c.mul_b = MB_SCALE;
      end
      PC_RESULT: begin
        c.finish = 1'b1;
      end
      PC_IDLE_OUT: begin
        c.finish = 1'b1;
      end
      default: begin
        c.finish = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dcme_if.sv =====
// ---------------------------------------------------------------------------
// dcme_if
// Valid/ready channels for motor ticks and step results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dcme_in_if;
  import dcme_pkg::*;
  logic valid;
  logic ready;
  logic start_req;
  cfg_t supply_voltage;
  cfg_t load_torque;

  modport source (output valid, start_req, supply_voltage, load_torque, input ready);
  modport sink (input valid, start_req, supply_voltage, load_torque, output ready);
endinterface

interface dcme_out_if;
  import dcme_pkg::*;
  logic  valid;
  logic  ready;
  logic  stepped;
  logic  done_res;
  step_t step_index;
  val_t  current;
  val_t  speed;
  val_t  scaled_speed;

  modport source (output valid, stepped, done_res, step_index, current, speed,
                  scaled_speed, input ready);
  modport sink (input valid, stepped, done_res, step_index, current, speed,
                scaled_speed, output ready);
endinterface

`default_nettype wire

// ===== rtl/dcme_datapath.sv =====
// ---------------------------------------------------------------------------
// dcme_datapath
// Shared multiplier and saturating adder driven by the microcode word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcme_datapath (
  input  logic            clk,
  input  dcme_pkg::ctrl_t ctrl,
  input  dcme_pkg::cfg_t  resistance,
  input  dcme_pkg::cfg_t  back_emf_const,
  input  dcme_pkg::cfg_t  torque_const,
  input  dcme_pkg::cfg_t  friction_coeff,
  input  dcme_pkg::cfg_t  dt_over_inductance,
  input  dcme_pkg::cfg_t  dt_over_inertia,
  input  dcme_pkg::cfg_t  supply_voltage,
  input  dcme_pkg::cfg_t  load_torque,
  input  dcme_pkg::val_t  cur_state,
  input  dcme_pkg::val_t  spd_state,
  output dcme_pkg::val_t  cur_new,
  output dcme_pkg::val_t  spd_new,
  output dcme_pkg::val_t  prod
);
  import dcme_pkg::*;

  val_t                            di;
  val_t                            dw;
  val_t                            mul_a;
  val_t                            mul_b;
  logic signed [2*VALUE_WIDTH-1:0] product;
  val_t                            alu_a;
  val_t                            alu_b;
  logic signed [VALUE_WIDTH:0]     alu_sum;
  val_t                            alu_res;

  always_comb begin
    unique case (ctrl.mul_a)
      MA_RES:  mul_a = val_t'(resistance);
      MA_KE:   mul_a = val_t'(back_emf_const);
      MA_KM:   mul_a = val_t'(torque_const);
      MA_FRIC: mul_a = val_t'(friction_coeff);
      MA_DTL:  mul_a = val_t'(dt_over_inductance);
      MA_DTJ:  mul_a = val_t'(dt_over_inertia);
      MA_SPD:  mul_a = spd_new;
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.mul_b)
      MB_CUR:   mul_b = cur_state;
      MB_SPD:   mul_b = spd_state;
      MB_DI:    mul_b = di;
      MB_DW:    mul_b = dw;
      MB_SCALE: mul_b = SCALE_Q;
      default:  mul_b = '0;
    endcase
  end

  assign product = mul_a * mul_b;

  always_comb begin
    unique case (ctrl.alu_a)
      AA_ZERO: alu_a = '0;
      AA_VOLT: alu_a = val_t'(supply_voltage);
      AA_DI:   alu_a = di;
      AA_DW:   alu_a = dw;
      AA_CUR:  alu_a = cur_state;
      AA_SPD:  alu_a = spd_state;
      default: alu_a = '0;
    endcase
  end

  assign alu_b = (ctrl.alu_b == AB_LOAD) ? val_t'(load_torque) : prod;

  always_comb begin
    if (ctrl.alu_op == OP_SUB) begin
      alu_sum = {alu_a[VALUE_WIDTH-1], alu_a} - {alu_b[VALUE_WIDTH-1], alu_b};
    end else begin
      alu_sum = {alu_a[VALUE_WIDTH-1], alu_a} + {alu_b[VALUE_WIDTH-1], alu_b};
    end
    alu_res = sat_sum(alu_sum);
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= sat_prod(product);
    end
    unique case (ctrl.dst)
      DST_NONE: ;
      DST_DI:   di      <= alu_res;
      DST_DW:   dw      <= alu_res;
      DST_CUR:  cur_new <= alu_res;
      DST_SPD:  spd_new <= alu_res;
      default:  ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/dc_motor_euler_step_top.sv =====
// ---------------------------------------------------------------------------
// dc_motor_euler_step_top
// One explicit-Euler tick of a DC motor model per input transfer.
// ---------------------------------------------------------------------------
// Usage:
//  in_ch carries one simulation tick: start_req, supply_voltage, load_torque.
//  out_ch returns exactly one result per tick: stepped, done_res, step_index,
//  current, speed and scaled_speed (speed times 400), all Q16.16 saturated.
//  Configuration registers are written through cfg_wr_en / cfg_index /
//  cfg_data; the user must write them only while the block is idle, as the
//  block does not enforce it. Writes to unused indexes are dropped.
//  A tick that steps the model runs ten microcode steps on one shared 32x32
//  multiplier; its result enters the output register at the last step and a
//  new tick is taken once the sequencer is idle. A tick with no run active and
//  no start request jumps to the idle-out step and returns an all-zero result.
//  The output register frees the sequencer: it accepts the next tick while a
//  result waits. If the receiver stalls when the next result is finished, the
//  sequencer holds on its last step until the output register drains.
//  Reset (rst, synchronous) clears the run state, drops any pending result
//  and loads the register defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dc_motor_euler_step_top_assert.svh"

module dc_motor_euler_step_top (
  input  logic                               clk,
  input  logic                               rst,
  dcme_in_if.sink                            in_ch,
  dcme_out_if.source                         out_ch,
  input  logic                               cfg_wr_en,
  input  logic [dcme_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  dcme_pkg::cfg_t                     cfg_data
);
  import dcme_pkg::*;

  // Configuration registers
  cfg_t  resistance;
  cfg_t  back_emf_const;
  cfg_t  torque_const;
  cfg_t  friction_coeff;
  cfg_t  dt_over_inductance;
  cfg_t  dt_over_inertia;
  step_t end_step;

  // Sequencer and run state
  logic  busy;
  pc_t   pc;
  logic  idle_tick;
  logic  running;
  step_t step_count;
  val_t  cur_state;
  val_t  spd_state;

  // Latched tick operands
  cfg_t  volt_reg;
  cfg_t  load_reg;

  // Output register
  logic  out_valid;
  logic  out_stepped;
  logic  out_done;
  step_t out_index;
  val_t  out_current;
  val_t  out_speed;
  val_t  out_scaled;

  ctrl_t word;
  ctrl_t ctrl;
  logic  stall;
  logic  in_xfer;
  logic  out_xfer;
  logic  finish;
  logic  done;
  val_t  cur_new;
  val_t  spd_new;
  val_t  prod;

  assign word     = ucode(pc);
  // Hold the last step while a finished result cannot enter the output register.
  assign stall    = word.finish && out_valid && !out_ch.ready;
  assign ctrl     = (busy && !stall) ? word : CTRL_NOP;
  assign finish   = busy && word.finish && !stall;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid && out_ch.ready;
  assign done     = step_count >= end_step;

  assign in_ch.ready = !busy;

  assign out_ch.valid        = out_valid;
  assign out_ch.stepped      = out_stepped;
  assign out_ch.done_res     = out_done;
  assign out_ch.step_index   = out_index;
  assign out_ch.current      = out_current;
  assign out_ch.speed        = out_speed;
  assign out_ch.scaled_speed = out_scaled;

  dcme_datapath u_datapath (
    .clk                (clk),
    .ctrl               (ctrl),
    .resistance         (resistance),
    .back_emf_const     (back_emf_const),
    .torque_const       (torque_const),
    .friction_coeff     (friction_coeff),
    .dt_over_inductance (dt_over_inductance),
    .dt_over_inertia    (dt_over_inertia),
    .supply_voltage     (volt_reg),
    .load_torque        (load_reg),
    .cur_state          (cur_state),
    .spd_state          (spd_state),
    .cur_new            (cur_new),
    .spd_new            (spd_new),
    .prod               (prod)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      resistance         <= cfg_t'(131072);
      back_emf_const     <= cfg_t'(6554);
      torque_const       <= cfg_t'(6554);
      friction_coeff     <= cfg_t'(32768);
      dt_over_inductance <= cfg_t'(6554);
      dt_over_inertia    <= cfg_t'(6554);
      end_step           <= step_t'(20000);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_RESISTANCE: resistance         <= cfg_data;
        REG_BACK_EMF:   back_emf_const     <= cfg_data;
        REG_TORQUE:     torque_const       <= cfg_data;
        REG_FRICTION:   friction_coeff     <= cfg_data;
        REG_DT_IND:     dt_over_inductance <= cfg_data;
        REG_DT_INERTIA: dt_over_inertia    <= cfg_data;
        REG_END_STEP:   end_step           <= cfg_data[STEP_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // Latch the tick operands on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      volt_reg <= in_ch.supply_voltage;
      load_reg <= in_ch.load_torque;
    end
  end

  // Sequencer, run state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pc         <= '0;
      idle_tick  <= 1'b0;
      running    <= 1'b0;
      step_count <= '0;
      cur_state  <= '0;
      spd_state  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy      <= 1'b1;
        pc        <= '0;
        // Run state is already zero when idle, so a start only sets running.
        idle_tick <= !running && !in_ch.start_req;
        if (!running && in_ch.start_req) begin
          running <= 1'b1;
        end
      end else if (busy && !stall) begin
        if (word.branch == BR_IDLE && idle_tick) begin
          pc <= word.target;
        end else if (word.finish) begin
          busy <= 1'b0;
        end else begin
          pc <= pc + pc_t'(1);
        end
      end

      // Retire the tick: load the output register and update the run state.
      // A retiring tick refills the register in the cycle it drains.
      if (finish) begin
        out_valid <= 1'b1;
        if (!idle_tick) begin
          if (done) begin
            running    <= 1'b0;
            step_count <= '0;
            cur_state  <= '0;
            spd_state  <= '0;
          end else begin
            step_count <= step_count + step_t'(1);
            cur_state  <= cur_new;
            spd_state  <= spd_new;
          end
        end
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload: an idle tick reports all zeros.
  always_ff @(posedge clk) begin
    if (finish) begin
      if (idle_tick) begin
        out_stepped <= 1'b0;
        out_done    <= 1'b0;
        out_index   <= '0;
        out_current <= '0;
        out_speed   <= '0;
        out_scaled  <= '0;
      end else begin
        out_stepped <= 1'b1;
        out_done    <= done;
        out_index   <= step_count;
        out_current <= cur_new;
        out_speed   <= spd_new;
        out_scaled  <= prod;
      end
    end
  end

  `DCME_ASSERT_NEXT(a_stall_holds_step, busy && stall, busy && (pc == $past(pc)), "sequencer moved during output stall")
  `DCME_ASSERT_SAME(a_idle_result_zero, out_valid && !out_stepped, !out_done && (out_index == '0) && (out_current == '0) && (out_speed == '0) && (out_scaled == '0), "idle tick result not zero")
  `DCME_ASSERT_SAME(a_run_ends_with_done, $fell(running) && !$past(rst), out_valid && out_done, "run ended without a done result")
  `DCME_ASSERT_SAME(a_idle_state_clear, !running, (cur_state == '0) && (spd_state == '0) && (step_count == '0), "run state not clear while idle")

endmodule

`default_nettype wire
